FILE: hw/rtl/address_to_dense_index_mapper_assert.svh
// Assertion macros for the address to dense index mapper checker.
// All properties are sampled on the rising edge of clock and are off during reset.
`ifndef ADDRESS_TO_DENSE_INDEX_MAPPER_ASSERT_SVH
`define ADDRESS_TO_DENSE_INDEX_MAPPER_ASSERT_SVH

// Same-cycle implication.
`define ADIM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adim check failed");

// Next-cycle implication.
`define ADIM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adim check failed");

`endif

FILE: hw/rtl/adim_pkg.sv
package adim_pkg;

   localparam int KEY_BYTES   = 6;
   localparam int MAX_ENTRIES = 64;

   localparam int KEY_W    = 48;
   localparam int KEY_BITS = (KEY_BYTES * 8 < KEY_W) ? KEY_BYTES * 8 : KEY_W;
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

   localparam int SLOT_W  = $clog2(MAX_ENTRIES);
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int LIMIT_W = 7;
   localparam int INDEX_W = 6;
   localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Search token walking down the cell chain.
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } tok_type;

   // Broadcast write into one cell.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key;
   } wr_type;

   // Low INDEX_W bits of a slot number, zero extended when the slot is narrower.
   function automatic logic [INDEX_W-1:0] to_index(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W+INDEX_W-1:0] wide;
      wide = {{INDEX_W{1'b0}}, slot};
      return wide[INDEX_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/adim_req_if.sv
interface adim_req_if;
   logic                      valid;
   logic                      ready;
   logic [adim_pkg::KEY_W-1:0] address_key;

   modport source (output valid, output address_key, input ready);
   modport sink   (input valid, input address_key, output ready);
endinterface

FILE: hw/rtl/adim_rsp_if.sv
interface adim_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [adim_pkg::INDEX_W-1:0] entry_index;
   logic                        newly_added;
   logic                        table_full;

   modport source (output valid, output entry_index, output newly_added,
                   output table_full, input ready);
   modport sink   (input valid, input entry_index, input newly_added,
                   input table_full, output ready);
endinterface

FILE: hw/rtl/adim_csr_if.sv
interface adim_csr_if;
   logic                        valid;
   logic                        ready;
   logic [adim_pkg::LIMIT_W-1:0] entry_limit;

   modport source (output valid, output entry_limit, input ready);
   modport sink   (input valid, input entry_limit, output ready);
endinterface

FILE: hw/rtl/adim_cell.sv
// One slot of the key store plus one stage of the search token pipe.
module adim_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [adim_pkg::SLOT_W-1:0] cell_id,
   input  logic [adim_pkg::CNT_W-1:0]  count,
   input  adim_pkg::wr_type            wr,
   input  adim_pkg::tok_type           tok_in,
   output adim_pkg::tok_type           tok_out
);

   logic [adim_pkg::KEY_W-1:0] key_ff;
   logic [adim_pkg::KEY_W-1:0] key_in;
   adim_pkg::tok_type          tok_ff;
   adim_pkg::tok_type          tok_in_next;
   logic                       in_range;
   logic                       match;

   // Only slots below the fill count hold written keys.
   assign in_range = adim_pkg::CNT_W'(cell_id) < count;
   assign match    = tok_in.valid && !tok_in.hit && in_range && (key_ff == tok_in.key);

   always_comb begin
      key_in = (wr.en && (wr.slot == cell_id)) ? wr.key : key_ff;
      tok_in_next = tok_in;
      if (match) begin
         tok_in_next.hit  = 1'b1;
         tok_in_next.slot = cell_id;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: hw/rtl/adim_ctrl.sv
// Handshakes, fill count, entry limit and the insert decision at the chain tail.
module adim_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   adim_req_if.sink                   req,
   adim_rsp_if.source                 rsp,
   adim_csr_if.sink                   csr,
   output adim_pkg::tok_type          tok_head,
   input  adim_pkg::tok_type          tok_tail,
   output logic [adim_pkg::CNT_W-1:0] count,
   output adim_pkg::wr_type           wr
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_DONE   = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [adim_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [adim_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   adim_pkg::tok_type                 head_ff, head_in;
   logic                              pend_hit_ff, pend_hit_in;
   logic [adim_pkg::SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [adim_pkg::KEY_W-1:0]        pend_key_ff, pend_key_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [adim_pkg::INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                              rsp_new_ff, rsp_new_in;
   logic                              rsp_full_ff, rsp_full_in;
   logic [adim_pkg::CMP_W-1:0]        lim_eff;
   logic                              is_full;
   logic                              rsp_free;
   logic                              req_fire;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      lim_eff = adim_pkg::CMP_W'(limit_ff);
      if (lim_eff > adim_pkg::CMP_W'(adim_pkg::MAX_ENTRIES)) begin
         lim_eff = adim_pkg::CMP_W'(adim_pkg::MAX_ENTRIES);
      end
   end
   assign is_full = adim_pkg::CMP_W'(count_ff) >= lim_eff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      limit_in     = (csr.valid && csr.ready) ? csr.entry_limit : limit_ff;
      head_in      = head_ff;
      head_in.valid = 1'b0;
      pend_hit_in  = pend_hit_ff;
      pend_slot_in = pend_slot_ff;
      pend_key_in  = pend_key_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      wr.en        = 1'b0;
      wr.slot      = count_ff[adim_pkg::SLOT_W-1:0];
      wr.key       = pend_key_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               head_in.valid = 1'b1;
               head_in.key   = req.address_key & adim_pkg::KEY_MASK;
               head_in.hit   = 1'b0;
               head_in.slot  = '0;
               state_in      = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (tok_tail.valid) begin
               pend_hit_in  = tok_tail.hit;
               pend_slot_in = tok_tail.slot;
               pend_key_in  = tok_tail.key;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (pend_hit_ff) begin
                  rsp_index_in = adim_pkg::to_index(pend_slot_ff);
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b0;
               end else if (is_full) begin
                  rsp_index_in = '0;
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b1;
               end else begin
                  rsp_index_in = adim_pkg::to_index(count_ff[adim_pkg::SLOT_W-1:0]);
                  rsp_new_in   = 1'b1;
                  rsp_full_in  = 1'b0;
                  wr.en        = 1'b1;
                  count_in     = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pend_hit_ff  <= pend_hit_in;
      pend_slot_ff <= pend_slot_in;
      pend_key_ff  <= pend_key_in;
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         limit_ff      <= adim_pkg::LIMIT_RESET;
         head_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign tok_head        = head_ff;
   assign count           = count_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.entry_index = rsp_index_ff;
   assign rsp.newly_added = rsp_new_ff;
   assign rsp.table_full  = rsp_full_ff;

endmodule

FILE: hw/rtl/address_to_dense_index_mapper.sv
// Address to dense index mapper. Each req word carries one address key; the rsp word
// returns the dense index the key got when first seen, or stores the key in the next
// free slot (0, 1, 2, ...) and returns that slot with newly_added set. An unknown key
// arriving once the count has reached entry_limit (clamped to the slot count) is not
// stored: table_full is set and entry_index reads 0. Keys match on their low
// 8*KEY_BYTES bits. entry_limit is written through the csr port, reset value 64, and
// should only change while the block is idle. One key is in flight at a time: after a
// req word is accepted, a search token walks the chain of MAX_ENTRIES cells one cell per
// clock, then the controller registers the tail token and loads the result into the rsp
// register once that register is free. The block returns to idle at the edge that loads
// the rsp register, so it takes the next req word even if the rsp word has not yet been
// taken; a result still stalled in the rsp register holds the next one back in the
// controller's pending registers. No clearing pass after reset; the block is ready in
// the first cycle out of reset.
module address_to_dense_index_mapper (
   input  logic       clock,
   input  logic       reset,
   adim_req_if.sink   req_chan,
   adim_rsp_if.source rsp_chan,
   adim_csr_if.sink   csr_chan
);

   // tok[0] is injected by the controller, tok[MAX_ENTRIES] comes off the tail.
   adim_pkg::tok_type          tok [0:adim_pkg::MAX_ENTRIES];
   adim_pkg::wr_type           wr;
   logic [adim_pkg::CNT_W-1:0] count;

   adim_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .rsp      (rsp_chan),
      .csr      (csr_chan),
      .tok_head (tok[0]),
      .tok_tail (tok[adim_pkg::MAX_ENTRIES]),
      .count    (count),
      .wr       (wr)
   );

   // Cell g owns slot g: it compares the passing token against its stored key
   // and latches a new key when the controller writes its slot.
   for (genvar g = 0; g < adim_pkg::MAX_ENTRIES; g++) begin : g_cell
      adim_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cell_id (adim_pkg::SLOT_W'(g)),
         .count   (count),
         .wr      (wr),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

endmodule

FILE: hw/rtl/adim_checker.sv
`include "address_to_dense_index_mapper_assert.svh"

module adim_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [adim_pkg::INDEX_W-1:0] entry_index,
   input logic                         newly_added,
   input logic                         table_full
);

   logic [adim_pkg::INDEX_W+1:0] rsp_word;

   assign rsp_word = {entry_index, newly_added, table_full};

   // A full response never carries an index or an insert.
   `ADIM_ASSERT_NOW(a_full_zero, rsp_valid && table_full, (entry_index == '0) && !newly_added)

   // Insert and full are exclusive.
   `ADIM_ASSERT_NOW(a_new_xor_full, rsp_valid, !(newly_added && table_full))

   // One key in flight: the cycle after acceptance the block is busy.
   `ADIM_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // A stalled result word holds.
   `ADIM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

endmodule

bind address_to_dense_index_mapper adim_checker u_adim_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .entry_index (rsp_chan.entry_index),
   .newly_added (rsp_chan.newly_added),
   .table_full  (rsp_chan.table_full)
);
